/* rtl/tsf_pkg.sv */
package tsf_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FRAC_BITS   = 16;
    localparam int MAX_EXTENT  = 1024;
    localparam int EXT_W       = 11;
    localparam int LAYER_W     = 9;
    localparam int LAYER_LIMIT = 256;
    localparam int COORD_W     = 32;
    localparam int TEXEL_W     = 32;
    localparam int CH_W        = 16;
    localparam int PROD_W      = COORD_W + EXT_W + 1;
    localparam int IDX_W       = PROD_W - FRAC_BITS;
    localparam int MAG_W       = IDX_W - 1;
    localparam int HALF        = 1 << (FRAC_BITS - 1);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEPTH  = 3'd2;
    localparam logic [2:0] REG_LAYERS = 3'd3;
    localparam logic [2:0] REG_DIM    = 3'd4;
    localparam logic [2:0] REG_WRAP   = 3'd5;
    localparam logic [2:0] REG_FILTER = 3'd6;

    localparam logic [1:0] DIM_1D = 2'd0;
    localparam logic [1:0] DIM_2D = 2'd1;

    typedef logic [EXT_W-1:0] ext_t;

    function automatic ext_t eff_extent(input ext_t raw);
        if (raw == '0)
            return ext_t'(1);
        if (raw > ext_t'(MAX_EXTENT))
            return ext_t'(MAX_EXTENT);
        return raw;
    endfunction

endpackage

/* rtl/tsf_if.sv */
interface tsf_in_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic [15:0]                        texel_index;
    logic [31:0]                        texel_word;
    logic signed [31:0]                 s_coord;
    logic signed [31:0]                 t_coord;
    logic signed [31:0]                 r_coord;
    logic signed [31:0]                 layer_coord;

    modport source (output valid, op, texel_index, texel_word, s_coord, t_coord, r_coord,
                    layer_coord, input ready);
    modport sink (input valid, op, texel_index, texel_word, s_coord, t_coord, r_coord,
                  layer_coord, output ready);
endinterface

interface tsf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha_channel;

    modport source (output valid, red, green, blue, alpha_channel, input ready);
    modport sink (input valid, red, green, blue, alpha_channel, output ready);
endinterface

/* rtl/tsf_ram.sv */
module tsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        else
            rdata <= mem[addr];
    end
endmodule

/* rtl/texture_sampler_filter_unit.sv */
// Nearest or linear (1D, 2D or 3D) sampler over a 64K-entry RGBA8 texel
// store. A write beat stores one texel. A sample beat is taken one at a
// time: it runs the 27-step repeat modulo on all three axes in parallel,
// the index and row address math in the EDGE, ZROW, YROW and XROW states,
// fetches one texel for nearest or 2, 4 or 8 for a linear blend from the
// single-port texel store that gives one texel per cycle, and for a linear
// blend runs one shared lerp multiplier that does seven lerps for each of
// the four channels. Results are in 8.8 byte scale and wait in an output
// register, so a new item is taken while the previous result is still pending;
// a finished sample holds while that register is still full.
module texture_sampler_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tsf_in_if.sink      in_ch,
    tsf_out_if.source   out_ch
);
    import tsf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_MOD   = 4'd2;
    localparam logic [3:0] ST_EDGE  = 4'd3;
    localparam logic [3:0] ST_ZROW  = 4'd4;
    localparam logic [3:0] ST_YROW  = 4'd5;
    localparam logic [3:0] ST_FETCH = 4'd6;
    localparam logic [3:0] ST_DRAIN = 4'd7;
    localparam logic [3:0] ST_BLEND = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;
    localparam logic [3:0] ST_XROW  = 4'd10;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [3:0]           state_reg;
    ext_t                 width_reg, height_reg, depth_reg;
    logic [LAYER_W-1:0]   layers_reg;
    logic [1:0]           dim_reg;
    logic [2:0]           wrap_reg;
    logic                 filter_reg;

    logic signed [COORD_W-1:0] crd_reg [3];
    logic signed [COORD_W-1:0] lay_reg;
    logic signed [IDX_W-1:0]   i0_reg [3];
    logic [FRAC_BITS-1:0]      fr_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    ext_t                      rem_reg [3];
    ext_t                      c0_reg [3];
    ext_t                      c1_reg [3];
    logic [LAYER_W-2:0]        layer_reg;
    logic [ADDR_W-1:0]         ld_reg;
    logic [ADDR_W-1:0]         zl_reg [2];
    logic [ADDR_W-1:0]         row_reg [4];
    logic [CNT_W-1:0]          cnt_reg;
    logic [2:0]                n_reg;
    logic                      rd_pend_reg;
    logic [2:0]                rd_slot_reg;
    logic [TEXEL_W-1:0]        t_reg [8];
    logic [CH_W-1:0]           acc_reg [6];
    logic [CH_W-1:0]           res_reg [4];
    logic [2:0]                step_reg;
    logic [1:0]                ch_reg;
    logic                      out_valid_reg;
    logic [CH_W-1:0]           out_reg [4];

    ext_t ext_eff [3];
    logic [LAYER_W-1:0] layers_eff;

    assign ext_eff[0] = eff_extent(width_reg);
    assign ext_eff[1] = eff_extent(height_reg);
    assign ext_eff[2] = eff_extent(depth_reg);
    assign layers_eff = (layers_reg == '0) ? LAYER_W'(1) :
                        (layers_reg > LAYER_W'(LAYER_LIMIT)) ? LAYER_W'(LAYER_LIMIT) : layers_reg;

    // configuration port
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_DEPTH:  prdata = 32'(depth_reg);
            REG_LAYERS: prdata = 32'(layers_reg);
            REG_DIM:    prdata = 32'(dim_reg);
            REG_WRAP:   prdata = 32'(wrap_reg);
            REG_FILTER: prdata = 32'(filter_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ext_t'(1);
            height_reg <= ext_t'(1);
            depth_reg  <= ext_t'(1);
            layers_reg <= LAYER_W'(1);
            dim_reg    <= DIM_2D;
            wrap_reg   <= '0;
            filter_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_WIDTH:  width_reg  <= pwdata[EXT_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[EXT_W-1:0];
                REG_DEPTH:  depth_reg  <= pwdata[EXT_W-1:0];
                REG_LAYERS: layers_reg <= pwdata[LAYER_W-1:0];
                REG_DIM:    dim_reg    <= pwdata[1:0];
                REG_WRAP:   wrap_reg   <= pwdata[2:0];
                REG_FILTER: filter_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // input and texel store
    logic                 in_acc;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ADDR_W-1:0]    fetch_addr;
    logic [TEXEL_W-1:0]   ram_rdata;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid & in_ch.ready;
    assign ram_we      = in_acc & (in_ch.op == OP_WRITE);
    assign ram_addr    = ram_we ? in_ch.texel_index[ADDR_W-1:0] : fetch_addr;

    tsf_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_ch.texel_word),
        .rdata (ram_rdata)
    );

    // per-axis scaling and edge handling
    logic signed [PROD_W-1:0] p_ax [3];
    ext_t                     rep0 [3], rep1 [3], cl0 [3], cl1 [3];
    logic signed [IDX_W-1:0]  i0p1 [3];
    logic signed [IDX_W-1:0]  ext_s [3];
    logic [EXT_W:0]           shl [3];

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            p_ax[ax] = crd_reg[ax] * $signed({1'b0, ext_eff[ax]}) - $signed(PROD_W'(HALF));
            shl[ax]  = {rem_reg[ax], mag_reg[ax][MAG_W-1]};
            ext_s[ax] = $signed({{(IDX_W-EXT_W){1'b0}}, ext_eff[ax]});
            i0p1[ax] = i0_reg[ax] + IDX_W'(1);
            if (i0_reg[ax] < 0 && rem_reg[ax] != '0)
                rep0[ax] = ext_eff[ax] - rem_reg[ax];
            else
                rep0[ax] = rem_reg[ax];
            rep1[ax] = (rep0[ax] + ext_t'(1) == ext_eff[ax]) ? '0 : rep0[ax] + ext_t'(1);
            if (i0_reg[ax] < 0)
                cl0[ax] = '0;
            else if (i0_reg[ax] > ext_s[ax] - IDX_W'(1))
                cl0[ax] = ext_eff[ax] - ext_t'(1);
            else
                cl0[ax] = i0_reg[ax][EXT_W-1:0];
            if (i0p1[ax] < 0)
                cl1[ax] = '0;
            else if (i0p1[ax] > ext_s[ax] - IDX_W'(1))
                cl1[ax] = ext_eff[ax] - ext_t'(1);
            else
                cl1[ax] = i0p1[ax][EXT_W-1:0];
        end
    end

    // layer: round half away from zero, negative values clamp to zero
    logic [COORD_W:0]     lay_sum;
    logic [COORD_W-FRAC_BITS:0] lay_rnd;
    logic [LAYER_W-2:0]   layer_q;

    assign lay_sum = {1'b0, lay_reg} + (COORD_W+1)'(HALF);
    assign lay_rnd = lay_sum[COORD_W:FRAC_BITS];

    always_comb
    begin
        if (lay_reg < 0)
            layer_q = '0;
        else if (lay_rnd > (COORD_W-FRAC_BITS+1)'(layers_eff - LAYER_W'(1)))
            layer_q = (LAYER_W-1)'(layers_eff - LAYER_W'(1));
        else
            layer_q = lay_rnd[LAYER_W-2:0];
    end

    // fetch selection
    logic [2:0] last_n;
    logic [2:0] sel;
    logic [2:0] mask;
    ext_t       xsel;

    always_comb
    begin
        if (!filter_reg)
            last_n = 3'd0;
        else if (dim_reg == DIM_1D)
            last_n = 3'd1;
        else if (dim_reg == DIM_2D)
            last_n = 3'd3;
        else
            last_n = 3'd7;
        if (dim_reg == DIM_1D)
            mask = 3'b001;
        else if (dim_reg == DIM_2D)
            mask = 3'b011;
        else
            mask = 3'b111;
        if (filter_reg)
            sel = n_reg;
        else
            sel = {fr_reg[2] > FRAC_BITS'(HALF), fr_reg[1] > FRAC_BITS'(HALF),
                   fr_reg[0] > FRAC_BITS'(HALF)};
        xsel = sel[0] ? c1_reg[0] : c0_reg[0];
    end

    assign fetch_addr = ADDR_W'(xsel) + row_reg[sel[2:1]];

    // row bases from the registered z rows
    logic [ADDR_W-1:0] row_calc [4];
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            row_calc[r] = (ADDR_W'(r[0] ? c1_reg[1] : c0_reg[1]) + zl_reg[r / 2])
                          * ADDR_W'(ext_eff[0]);
    end

    // shared lerp: v0 + (v1 - v0) * f, rounded
    logic [CH_W-1:0]                  la, lb;
    logic [FRAC_BITS-1:0]             lf;
    logic [2:0]                       ia, ib;
    logic signed [CH_W:0]             ldiff;
    logic signed [CH_W+FRAC_BITS+1:0] lprod;
    logic signed [CH_W+FRAC_BITS+1:0] lsum;
    logic [CH_W-1:0]                  lres;

    always_comb
    begin
        ia = 3'({step_reg[1:0], 1'b0}) & mask;
        ib = 3'({step_reg[1:0], 1'b1}) & mask;
        case (step_reg)
            3'd4:
            begin
                la = acc_reg[0];
                lb = acc_reg[1];
                lf = fr_reg[1];
            end
            3'd5:
            begin
                la = acc_reg[2];
                lb = acc_reg[3];
                lf = fr_reg[1];
            end
            3'd6:
            begin
                la = acc_reg[4];
                lb = acc_reg[5];
                lf = fr_reg[2];
            end
            default:
            begin
                la = {t_reg[ia][8*ch_reg +: 8], 8'h00};
                lb = {t_reg[ib][8*ch_reg +: 8], 8'h00};
                lf = fr_reg[0];
            end
        endcase
        ldiff = $signed({1'b0, lb}) - $signed({1'b0, la});
        lprod = ldiff * $signed({1'b0, lf});
        lsum  = $signed({2'b00, la, {FRAC_BITS{1'b0}}}) + lprod
                + $signed((CH_W+FRAC_BITS+2)'(HALF));
        lres  = lsum[FRAC_BITS +: CH_W];
    end

    // sequencer
    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == ST_FETCH);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:  if (in_acc && in_ch.op == OP_SAMPLE) state_reg <= ST_PREP;
                ST_PREP:  state_reg <= ST_MOD;
                ST_MOD:   if (cnt_reg == CNT_W'(MAG_W - 1)) state_reg <= ST_EDGE;
                ST_EDGE:  state_reg <= ST_ZROW;
                ST_ZROW:  state_reg <= ST_YROW;
                ST_YROW:  state_reg <= ST_XROW;
                ST_XROW:  state_reg <= ST_FETCH;
                ST_FETCH: if (n_reg == last_n) state_reg <= ST_DRAIN;
                ST_DRAIN: state_reg <= filter_reg ? ST_BLEND : ST_DONE;
                ST_BLEND: if (step_reg == 3'd6 && ch_reg == 2'd3) state_reg <= ST_DONE;
                ST_DONE:  if (out_load) state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            crd_reg[0] <= in_ch.s_coord;
            crd_reg[1] <= in_ch.t_coord;
            crd_reg[2] <= in_ch.r_coord;
            lay_reg    <= in_ch.layer_coord;
        end
        if (state_reg == ST_PREP)
        begin
            cnt_reg <= '0;
            for (int ax = 0; ax < 3; ax++)
            begin
                i0_reg[ax]  <= p_ax[ax][PROD_W-1:FRAC_BITS];
                fr_reg[ax]  <= p_ax[ax][FRAC_BITS-1:0];
                mag_reg[ax] <= p_ax[ax][PROD_W-1] ? MAG_W'(-p_ax[ax][PROD_W-1:FRAC_BITS])
                                                  : p_ax[ax][PROD_W-2:FRAC_BITS];
                rem_reg[ax] <= '0;
            end
        end
        if (state_reg == ST_MOD)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            for (int ax = 0; ax < 3; ax++)
            begin
                mag_reg[ax] <= mag_reg[ax] << 1;
                if (shl[ax] >= {1'b0, ext_eff[ax]})
                    rem_reg[ax] <= EXT_W'(shl[ax] - {1'b0, ext_eff[ax]});
                else
                    rem_reg[ax] <= shl[ax][EXT_W-1:0];
            end
        end
        if (state_reg == ST_EDGE)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                c0_reg[ax] <= wrap_reg[ax] ? cl0[ax] : rep0[ax];
                c1_reg[ax] <= wrap_reg[ax] ? cl1[ax] : rep1[ax];
            end
            layer_reg <= layer_q;
        end
        if (state_reg == ST_ZROW)
            ld_reg <= ADDR_W'(layer_reg) * ADDR_W'(ext_eff[2]);
        if (state_reg == ST_YROW)
        begin
            zl_reg[0] <= (ADDR_W'(c0_reg[2]) + ld_reg) * ADDR_W'(ext_eff[1]);
            zl_reg[1] <= (ADDR_W'(c1_reg[2]) + ld_reg) * ADDR_W'(ext_eff[1]);
            n_reg     <= '0;
        end
        if (state_reg == ST_XROW)
        begin
            for (int r = 0; r < 4; r++)
                row_reg[r] <= row_calc[r];
        end
        if (state_reg == ST_FETCH)
        begin
            n_reg       <= n_reg + 3'd1;
            rd_slot_reg <= n_reg;
        end
        if (rd_pend_reg)
            t_reg[rd_slot_reg] <= ram_rdata;
        if (state_reg == ST_DRAIN)
        begin
            step_reg <= '0;
            ch_reg   <= '0;
        end
        if (state_reg == ST_BLEND)
        begin
            if (step_reg == 3'd6)
            begin
                res_reg[ch_reg] <= lres;
                step_reg        <= '0;
                ch_reg          <= ch_reg + 2'd1;
            end
            else
            begin
                acc_reg[step_reg] <= lres;
                step_reg          <= step_reg + 3'd1;
            end
        end
        if (out_load)
        begin
            for (int c = 0; c < 4; c++)
                out_reg[c] <= filter_reg ? res_reg[c] : {t_reg[0][8*c +: 8], 8'h00};
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.red           = out_reg[0];
    assign out_ch.green         = out_reg[1];
    assign out_ch.blue          = out_reg[2];
    assign out_ch.alpha_channel = out_reg[3];
endmodule
